[rtl/core/ira_pkg.sv]
package ira_pkg;

  localparam int VALUE_BITS = 32;
  localparam int RADIX_BITS = 6;
  localparam int DIGIT_BITS = 6;
  localparam int CHAR_BITS  = 8;
  localparam int STEP_BITS  = 8;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);

  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0]        radix;
  } in_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] ascii_char;
    logic                 last_char;
    logic                 bad_radix;
  } out_t;

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] c;
    begin
      if (d < DIGIT_BITS'(10)) begin
        c = CHAR_ZERO + CHAR_BITS'(d);
      end else if (d < DIGIT_BITS'(36)) begin
        c = CHAR_LOW_A + CHAR_BITS'(d) - CHAR_BITS'(10);
      end else begin
        c = CHAR_NUL;
      end
      return c;
    end
  endfunction

endpackage

[rtl/core/ira_ram.sv]
module ira_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/integer_to_radix_ascii.sv]
// Signed integer to radix text, radix 2 to 36.
// Input: pulse start with in_data (value, radix); the item transfers when
// start is high and busy is low. busy stays high for the whole conversion.
// Output: one character per cycle marked by out_strobe, most significant
// first, with a leading '-' for negative values; last_char marks the end.
// The receiver cannot stall: every strobed result is taken in its cycle.
// An invalid radix gives one result (char 0, bad_radix set) in the cycle after
// the transfer, and busy never rises.
// Timing: each digit comes from a division of the quotient in the shared
// divider, which does eight restoring compare-subtract steps per cycle against the
// radix. Characters then leave one per cycle after a registered memory read.
// A minus sign leaves first, from the ST_PRE state that every conversion passes
// through, and adds no busy time. The last character leaves in the cycle after
// busy falls, when the next transfer may be taken.
// Reset (synchronous, rst_n low) returns the sequencer to idle and drops
// any strobe; digit memory contents are not cleared.
module integer_to_radix_ascii #(
  parameter int WORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ira_pkg::in_t  in_data,
  output logic          out_strobe,
  output ira_pkg::out_t out_data
);

  localparam int PASSES = (WORD_BITS + ira_pkg::STEP_BITS - 1) / ira_pkg::STEP_BITS;
  localparam int QW     = PASSES * ira_pkg::STEP_BITS;
  localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int CW     = $clog2(WORD_BITS + 1);
  localparam int AW     = $clog2(WORD_BITS);
  localparam int DB     = ira_pkg::DIGIT_BITS;
  localparam int RB     = ira_pkg::RADIX_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PRE  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [QW-1:0]       quo_r, quo_nxt;
  logic [DB-1:0]       rem_r, rem_nxt;
  logic [RB-1:0]       radix_r, radix_nxt;
  logic                neg_r, neg_nxt;
  logic [PW-1:0]       pass_r, pass_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  ira_pkg::out_t       out_data_r, out_data_nxt;

  logic [WORD_BITS-1:0] v_in;
  logic [WORD_BITS-1:0] mag_in;
  logic                 radix_bad;
  logic [QW-1:0]        quo_c;
  logic [DB-1:0]        rem_c;
  logic [DB:0]          trial;
  logic                 last_pass;
  logic                 wr_en;
  logic [CW-1:0]        rd_idx;
  logic [DB-1:0]        rd_digit;

  assign v_in      = WORD_BITS'(in_data.value);
  assign mag_in    = v_in[WORD_BITS-1] ? (~v_in + WORD_BITS'(1)) : v_in;
  assign radix_bad = (in_data.radix < ira_pkg::RADIX_MIN) ||
                     (in_data.radix > ira_pkg::RADIX_MAX);
  assign last_pass = (pass_r == PW'(PASSES - 1));

  always_comb begin
    quo_c = quo_r;
    rem_c = rem_r;
    trial = '0;
    for (int k = 0; k < ira_pkg::STEP_BITS; k++) begin
      trial = {rem_c, quo_c[QW-1]};
      quo_c = {quo_c[QW-2:0], 1'b0};
      if (trial >= {1'b0, radix_r}) begin
        trial    = trial - {1'b0, radix_r};
        quo_c[0] = 1'b1;
      end
      rem_c = trial[DB-1:0];
    end
  end

  assign wr_en  = (state_r == ST_DIV) && last_pass;
  assign rd_idx = (state_r == ST_PRE) ? (cnt_r - CW'(1)) : (cnt_r - CW'(2));

  ira_ram #(
    .WIDTH(DB),
    .DEPTH(WORD_BITS)
  ) u_digits (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(cnt_r[AW-1:0]),
    .wr_data(rem_c),
    .rd_addr(rd_idx[AW-1:0]),
    .rd_data(rd_digit)
  );

  always_comb begin
    state_nxt      = state_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    radix_nxt      = radix_r;
    neg_nxt        = neg_r;
    pass_nxt       = pass_r;
    cnt_nxt        = cnt_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (radix_bad) begin
            out_strobe_nxt          = 1'b1;
            out_data_nxt.ascii_char = ira_pkg::CHAR_NUL;
            out_data_nxt.last_char  = 1'b1;
            out_data_nxt.bad_radix  = 1'b1;
          end else begin
            quo_nxt   = QW'(mag_in);
            rem_nxt   = '0;
            radix_nxt = in_data.radix;
            neg_nxt   = v_in[WORD_BITS-1];
            pass_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        quo_nxt  = quo_c;
        rem_nxt  = rem_c;
        pass_nxt = pass_r + PW'(1);
        if (last_pass) begin
          rem_nxt  = '0;
          pass_nxt = '0;
          cnt_nxt  = cnt_r + CW'(1);
          if ((quo_c == '0) || (cnt_r == CW'(WORD_BITS - 1))) begin
            state_nxt = ST_PRE;
          end
        end
      end
      ST_PRE: begin
        if (neg_r) begin
          out_strobe_nxt          = 1'b1;
          out_data_nxt.ascii_char = ira_pkg::CHAR_MINUS;
          out_data_nxt.last_char  = 1'b0;
          out_data_nxt.bad_radix  = 1'b0;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_strobe_nxt          = 1'b1;
        out_data_nxt.ascii_char = ira_pkg::digit_char(rd_digit);
        out_data_nxt.last_char  = (cnt_r == CW'(1));
        out_data_nxt.bad_radix  = 1'b0;
        cnt_nxt                 = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      quo_r        <= '0;
      neg_r        <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      quo_r        <= quo_nxt;
      neg_r        <= neg_nxt;
      cnt_r        <= cnt_nxt;
    end
    rem_r      <= rem_nxt;
    radix_r    <= radix_nxt;
    pass_r     <= pass_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

[bench/integer_to_radix_ascii_test.sv]
module integer_to_radix_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 200;
  localparam int RANDOM_ITEMS = 230;
  localparam int REPORT_CAP = 100;

  localparam int VALUE_BITS = ira_pkg::VALUE_BITS;
  localparam int RADIX_BITS = ira_pkg::RADIX_BITS;
  localparam int DIGIT_BITS = ira_pkg::DIGIT_BITS;
  localparam int CHAR_BITS  = ira_pkg::CHAR_BITS;

  class radix_text_board;
    ira_pkg::out_t pending_chars[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_request(ira_pkg::in_t req);
      string glyphs = "0123456789abcdefghijklmnopqrstuvwxyz";
      logic [VALUE_BITS-1:0] raw;
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] base;
      logic [DIGIT_BITS-1:0] digits[$];
      ira_pkg::out_t ch;
      raw = req.value;
      if (req.radix < ira_pkg::RADIX_MIN || req.radix > ira_pkg::RADIX_MAX) begin
        ch.ascii_char = ira_pkg::CHAR_NUL;
        ch.last_char = 1'b1;
        ch.bad_radix = 1'b1;
        pending_chars.push_back(ch);
        return;
      end
      base = VALUE_BITS'(req.radix);
      mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
      do begin
        digits.push_front(DIGIT_BITS'(mag % base));
        mag = mag / base;
      end while (mag != '0);
      if (raw[VALUE_BITS-1]) begin
        ch.ascii_char = ira_pkg::CHAR_MINUS;
        ch.last_char = 1'b0;
        ch.bad_radix = 1'b0;
        pending_chars.push_back(ch);
      end
      foreach (digits[i]) begin
        ch.ascii_char = CHAR_BITS'(glyphs[digits[i]]);
        ch.last_char = (i == digits.size() - 1);
        ch.bad_radix = 1'b0;
        pending_chars.push_back(ch);
      end
    endfunction

    function void check_char(ira_pkg::out_t got);
      ira_pkg::out_t want;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: unexpected char, expected none, actual char %h last %b bad %b",
                   $time, got.ascii_char, got.last_char, got.bad_radix);
        return;
      end
      want = pending_chars.pop_front();
      if (got.ascii_char !== want.ascii_char || got.last_char !== want.last_char ||
          got.bad_radix !== want.bad_radix) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: mismatch, expected char %h last %b bad %b, actual char %h last %b bad %b",
                   $time, want.ascii_char, want.last_char, want.bad_radix,
                   got.ascii_char, got.last_char, got.bad_radix);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  ira_pkg::in_t in_data;
  logic out_strobe;
  ira_pkg::out_t out_data;

  radix_text_board board;
  int idle_cycles;
  int burst_left;

  integer_to_radix_ascii #(.WORD_BITS(VALUE_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    idle_cycles = 0;
    burst_left = 0;
    board = new();
  end

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      board.check_char(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(5, 20);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic send_value(input logic signed [VALUE_BITS-1:0] value,
                            input logic [RADIX_BITS-1:0] radix);
    ira_pkg::in_t req;
    int gap;
    req.value = value;
    req.radix = radix;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    board.note_request(req);
  endtask

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    logic signed [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 40);
      1: v = -$signed(VALUE_BITS'($urandom_range(0, 40)));
      2: v = $urandom >> $urandom_range(0, 31);
      3: begin
        case ($urandom_range(0, 4))
          0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
          1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
          2: v = '1;
          3: v = '0;
          default: v = 1;
        endcase
      end
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 3) == 0) v = -v;
    return v;
  endfunction

  function automatic logic [RADIX_BITS-1:0] pick_radix();
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) return RADIX_BITS'($urandom_range(0, 1));
      return RADIX_BITS'($urandom_range(37, 63));
    end
    case ($urandom_range(0, 5))
      0: return ira_pkg::RADIX_MIN;
      1: return ira_pkg::RADIX_MAX;
      default: return RADIX_BITS'($urandom_range(2, 36));
    endcase
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_value(0, 6'd10);
    send_value(0, ira_pkg::RADIX_MIN);
    send_value(32'sh7fffffff, ira_pkg::RADIX_MIN);
    send_value(32'sh7fffffff, ira_pkg::RADIX_MAX);
    send_value(32'sh7fffffff, 6'd16);
    send_value(32'sh80000000, ira_pkg::RADIX_MIN);
    send_value(32'sh80000000, 6'd10);
    send_value(32'sh80000000, 6'd8);
    send_value(32'sh80000000, ira_pkg::RADIX_MAX);
    send_value(-1, ira_pkg::RADIX_MIN);
    send_value(1, ira_pkg::RADIX_MAX);
    send_value(35, ira_pkg::RADIX_MAX);
    send_value(-35, ira_pkg::RADIX_MAX);
    send_value(12345, 6'd10);
    send_value(-12345, 6'd7);
    send_value(32'sh55aa55aa, 6'd3);
    send_value(0, 6'd0);
    send_value(-1, 6'd1);
    send_value(12345, 6'd37);
    send_value(32'sh80000000, 6'd63);
    send_value(-1, 6'd37);
    send_value(100, 6'd9);

    repeat (RANDOM_ITEMS) send_value(pick_value(), pick_radix());

    @(negedge clk);
    start <= 1'b0;
    while (board.pending_chars.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
